// ===== rtl/zrt_pkg.sv =====
// ----------------------------------------------------------------------------
// zrt_pkg
// Shared types and constants for the zigzag rail transposer.
// ----------------------------------------------------------------------------
package zrt_pkg;

  localparam int unsigned MaxLen = 64;
  localparam int unsigned RowsW  = 7;
  localparam int unsigned CharW  = 8;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             last_in;
  } zrt_in_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             last_out;
    logic             overflow;
  } zrt_out_t;

  // attributes of a read in flight; the byte itself comes from the buffer
  typedef struct packed {
    logic valid;
    logic last;
    logic ovf;
  } zrt_tag_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } zrt_state_e;

endpackage

// ===== rtl/zrt_buffer.sv =====
// ----------------------------------------------------------------------------
// zrt_buffer
// Message byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module zrt_buffer #(
  parameter int unsigned MAX_LEN = zrt_pkg::MaxLen
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(MAX_LEN)-1:0]       wr_addr_i,
  input  logic [zrt_pkg::CharW-1:0]        wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(MAX_LEN)-1:0]       rd_addr_i,
  output logic [zrt_pkg::CharW-1:0]        rd_data_o
);

  logic [zrt_pkg::CharW-1:0] mem_q [MAX_LEN];
  logic [zrt_pkg::CharW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rdata_q;

endmodule

// ===== rtl/zrt_sequencer.sv =====
// ----------------------------------------------------------------------------
// zrt_sequencer
// Load/emit control: stores incoming bytes, then walks the buffer in rail
// order issuing one read per cycle when the output side has room.
// ----------------------------------------------------------------------------
module zrt_sequencer #(
  parameter int unsigned MAX_LEN = zrt_pkg::MaxLen
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  zrt_pkg::zrt_in_t                 in_data_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [zrt_pkg::RowsW-1:0]        cfg_data_i,
  output logic                             wr_en_o,
  output logic [$clog2(MAX_LEN)-1:0]       wr_addr_o,
  output logic [zrt_pkg::CharW-1:0]        wr_data_o,
  output logic                             rd_en_o,
  output logic [$clog2(MAX_LEN)-1:0]       rd_addr_o,
  output zrt_pkg::zrt_tag_t                tag_o,
  input  logic                             credit_ok_i
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  // index arithmetic: base + period stays below 3 * MAX_LEN
  localparam int unsigned IW = (CW + 2 > 8) ? CW + 2 : 8;
  localparam int unsigned RW = zrt_pkg::RowsW;

  zrt_pkg::zrt_state_e state_q, state_d;

  logic [RW-1:0] num_rows_q;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [CW-1:0] len_q, len_d;
  logic [RW-1:0] rails_q, rails_d;
  logic [IW-1:0] period_q, period_d;
  logic [RW-1:0] rail_q, rail_d;
  logic [IW-1:0] base_q, base_d;
  logic          phase_q, phase_d;
  logic [CW-1:0] sent_q, sent_d;

  logic          accept;
  logic          has_room;
  logic [CW-1:0] new_len;
  logic [IW-1:0] new_len_x;
  logic [IW-1:0] rows_x;
  logic          passthru;
  logic [IW-1:0] rail_x;
  logic [IW-1:0] len_x;
  logic [IW-1:0] idx_fwd;
  logic [IW-1:0] idx_alt;
  logic [IW-1:0] base_nxt;
  logic [IW-1:0] idx_nxt;
  logic          mid_rail;
  logic          last_rd;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != zrt_pkg::ST_LOAD);
  assign accept      = in_valid_i && !in_stall_o;
  assign has_room    = (count_q < CW'(MAX_LEN));

  assign wr_en_o   = accept && has_room;
  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = in_data_i.char_in;

  assign new_len   = has_room ? count_q + CW'(1) : count_q;
  assign new_len_x = IW'(new_len);
  assign rows_x    = IW'(num_rows_q);
  assign passthru  = (num_rows_q <= RW'(1)) || (rows_x >= new_len_x);

  assign rail_x   = IW'(rail_q);
  assign len_x    = IW'(len_q);
  assign idx_fwd  = base_q + rail_x;
  assign idx_alt  = base_q + period_q - rail_x;
  assign base_nxt = base_q + period_q;
  assign idx_nxt  = base_nxt + rail_x;
  assign mid_rail = (rail_q != '0) && (rail_q != rails_q - RW'(1));
  assign last_rd  = (sent_q == len_q - CW'(1));

  assign rd_addr_o = phase_q ? idx_alt[AW-1:0] : idx_fwd[AW-1:0];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    len_d     = len_q;
    rails_d   = rails_q;
    period_d  = period_q;
    rail_d    = rail_q;
    base_d    = base_q;
    phase_d   = phase_q;
    sent_d    = sent_q;
    rd_en_o   = 1'b0;
    tag_o     = '0;
    case (state_q)
      zrt_pkg::ST_LOAD: begin
        if (accept) begin
          count_d   = new_len;
          dropped_d = dropped_q || !has_room;
          if (in_data_i.last_in) begin
            state_d = zrt_pkg::ST_EMIT;
            len_d   = new_len;
            rail_d  = '0;
            base_d  = '0;
            phase_d = 1'b0;
            sent_d  = '0;
            // one rail stepping by one gives the message unchanged
            if (passthru) begin
              rails_d  = RW'(1);
              period_d = IW'(1);
            end else begin
              rails_d  = num_rows_q;
              period_d = IW'({num_rows_q - RW'(1), 1'b0});
            end
          end
        end
      end
      zrt_pkg::ST_EMIT: begin
        if (credit_ok_i) begin
          rd_en_o   = 1'b1;
          tag_o     = '{valid: 1'b1, last: last_rd, ovf: dropped_q};
          sent_d    = sent_q + CW'(1);
          if (!phase_q && mid_rail && (idx_alt < len_x)) begin
            phase_d = 1'b1;
          end else if (idx_nxt < len_x) begin
            phase_d = 1'b0;
            base_d  = base_nxt;
          end else begin
            phase_d = 1'b0;
            base_d  = '0;
            rail_d  = rail_q + RW'(1);
          end
          if (last_rd) begin
            state_d   = zrt_pkg::ST_LOAD;
            count_d   = '0;
            dropped_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = zrt_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= zrt_pkg::ST_LOAD;
      num_rows_q <= RW'(1);
      count_q    <= '0;
      dropped_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_rows_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    rails_q  <= rails_d;
    period_q <= period_d;
    rail_q   <= rail_d;
    base_q   <= base_d;
    phase_q  <= phase_d;
    sent_q   <= sent_d;
  end

endmodule

// ===== rtl/zrt_out_queue.sv =====
// ----------------------------------------------------------------------------
// zrt_out_queue
// Two-entry result queue behind the buffer read; grants a read only when
// the result it returns is sure to find a slot.
// ----------------------------------------------------------------------------
module zrt_out_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  zrt_pkg::zrt_tag_t           tag_i,
  input  logic [zrt_pkg::CharW-1:0]   rd_data_i,
  output logic                        credit_ok_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output zrt_pkg::zrt_out_t           out_data_o
);

  zrt_pkg::zrt_tag_t pend_q;
  logic [1:0]        cnt_q, cnt_d;
  zrt_pkg::zrt_out_t slot0_q, slot0_d;
  zrt_pkg::zrt_out_t slot1_q, slot1_d;
  zrt_pkg::zrt_out_t entry;
  logic              pop;
  logic [1:0]        cnt_after;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign cnt_after   = cnt_q - {1'b0, pop};
  assign credit_ok_o = (cnt_after + {1'b0, pend_q.valid}) < 2'd2;
  assign entry       = '{char_out: rd_data_i, last_out: pend_q.last, overflow: pend_q.ovf};

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (pend_q.valid) begin
      if (cnt_after == 2'd0) begin
        slot0_d = entry;
      end else begin
        slot1_d = entry;
      end
    end
    cnt_d = cnt_after + {1'b0, pend_q.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= 2'd0;
    end else begin
      pend_q <= tag_i;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;

endmodule

// ===== rtl/zigzag_rail_transposer.sv =====
// ----------------------------------------------------------------------------
// zigzag_rail_transposer
// Buffers one message and emits it in rail fence (zigzag) order.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+--------------------------------
//   in      | in  | in_valid_i/stall_o | zrt_in_t  (char_in, last_in)
//   out     | out | out_valid_o/stall_i| zrt_out_t (char_out, last_out,
//           |     |                    |            overflow)
//   cfg     | in  | cfg_valid_i/ready_o| num_rows, 7 bits
//
// Loading takes one byte per cycle. After the last byte, input stalls while
// the sequencer issues one buffer read per cycle when the output queue has
// room; each result passes the buffer's read register, then a queue slot.
// The single-port read into a two-entry queue sets the emit rate; output
// stalls hold back reads, never drop them. Input resumes once every read of
// the message is issued. Reset clears control only; the buffer needs no clear.
// ----------------------------------------------------------------------------
module zigzag_rail_transposer #(
  parameter int unsigned MAX_LEN = zrt_pkg::MaxLen
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  zrt_pkg::zrt_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output zrt_pkg::zrt_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [zrt_pkg::RowsW-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_LEN);

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [zrt_pkg::CharW-1:0]  wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [zrt_pkg::CharW-1:0]  rd_data;
  zrt_pkg::zrt_tag_t          tag;
  logic                       credit_ok;

  zrt_sequencer #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .tag_o       (tag),
    .credit_ok_i (credit_ok)
  );

  zrt_buffer #(
    .MAX_LEN (MAX_LEN)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  zrt_out_queue u_oq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .rd_data_i   (rd_data),
    .credit_ok_o (credit_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/zrt_checker.sv =====
// ----------------------------------------------------------------------------
// zrt_checker
// Port-level checks for the zigzag rail transposer, bound to the top level.
// ----------------------------------------------------------------------------
module zrt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input zrt_pkg::zrt_in_t    in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input zrt_pkg::zrt_out_t   out_data_o
);

  // a stalled result request stays up
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped under stall");

  // the last byte starts emission, so input must stall right after it
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_in |=> in_stall_o)
    else $error("input not stalled after last byte");

  // overflow flag is constant across one message's results
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_out) ##1 out_valid_o
      |-> out_data_o.overflow == $past(out_data_o.overflow))
    else $error("overflow flag changed within a message");

endmodule

bind zigzag_rail_transposer zrt_checker u_zrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
